### hdl/are_pkg.sv
`timescale 1ns / 1ps
// Package for the axis reduction engine: mode codes, register indexes and
// the state type of the back end.
package are_pkg;

    typedef enum logic [2:0] {
        MODE_SUM    = 3'd0,
        MODE_MEAN   = 3'd1,
        MODE_MAX    = 3'd2,
        MODE_MIN    = 3'd3,
        MODE_L1     = 3'd4,
        MODE_L2     = 3'd5,
        MODE_ARGMAX = 3'd6,
        MODE_ARGMIN = 3'd7
    } mode_t;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_AXIS  = 2'd1;
    localparam logic [1:0] REG_INNER = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_WRITE,
        ST_FINISH,
        ST_OUT
    } state_t;

endpackage

### hdl/are_front.sv
`timescale 1ns / 1ps
// Front end: accepts samples, walks the inner and axis counters and tags
// each beat with its position, axis index and group flags. Uses are_pkg.
module are_front
    import are_pkg::*;
#(
    parameter int INNER_MAX = 1024,
    parameter int AXIS_MAX  = 65536,
    parameter int PW        = 10,
    parameter int AW        = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          restart,
    input  logic [16:0]   axis_len,
    input  logic [10:0]   inner_len,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [31:0]   sample,
    output logic          q_valid,
    input  logic          q_ready,
    output logic [31+PW+AW+2:0] q_data
);
    localparam int AXW = $clog2(AXIS_MAX + 1);
    localparam int INW = $clog2(INNER_MAX + 1);

    logic [AW-1:0] axis_cnt_reg;
    logic [PW-1:0] inner_cnt_reg;
    logic [AXW-1:0] alen;
    logic [INW-1:0] ilen;
    logic          last_axis, last_inner;

    always_comb begin
        if (axis_len == 17'd0) alen = AXW'(1);
        else if ({15'd0, axis_len} > 32'(AXIS_MAX)) alen = AXW'(AXIS_MAX);
        else alen = AXW'(axis_len);
        if (inner_len == 11'd0) ilen = INW'(1);
        else if ({21'd0, inner_len} > 32'(INNER_MAX)) ilen = INW'(INNER_MAX);
        else ilen = INW'(inner_len);
    end

    assign last_axis  = (32'(axis_cnt_reg) + 32'd1) >= 32'(alen);
    assign last_inner = (32'(inner_cnt_reg) + 32'd1) >= 32'(ilen);
    assign s_tready = q_ready;
    assign q_valid  = s_tvalid;
    assign q_data   = {last_axis, (axis_cnt_reg == '0), axis_cnt_reg, inner_cnt_reg, sample};

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            axis_cnt_reg  <= '0;
            inner_cnt_reg <= '0;
        end else if (s_tvalid && q_ready) begin
            if (last_inner) begin
                inner_cnt_reg <= '0;
                axis_cnt_reg  <= last_axis ? '0 : axis_cnt_reg + 1'b1;
            end else begin
                inner_cnt_reg <= inner_cnt_reg + 1'b1;
            end
        end
    end
endmodule

### hdl/are_queue.sv
`timescale 1ns / 1ps
// Short two-entry queue between the front and the back end.
// Depends on are_pkg only for house style.
module are_queue
    import are_pkg::*;
#(
    parameter int W = 60
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);
    logic [W-1:0] mem_reg [2];
    logic         wp_reg, rp_reg;
    logic [1:0]   cnt_reg;
    logic         push, pop;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_data  = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= in_data;
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

### hdl/are_back.sv
`timescale 1ns / 1ps
// Back end: read-modify-write of the per-position state memories, then the
// finishing step (serial divide or serial root) and the output register.
module are_back
    import are_pkg::*;
#(
    parameter int INNER_MAX = 1024,
    parameter int AXIS_MAX  = 65536,
    parameter int PW        = 10,
    parameter int AW        = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  mode_t         mode,
    input  logic [16:0]   axis_len,
    input  logic          q_valid,
    output logic          q_ready,
    input  logic [31+PW+AW+2:0] q_data,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [63:0]   value,
    output logic [9:0]    inner_position,
    output logic          saturated
);
    localparam int AXW = $clog2(AXIS_MAX + 1);
    localparam int DEPTH = INNER_MAX;

    logic [63:0] acc_mem [DEPTH];
    logic [AW-1:0] idx_mem [DEPTH];
    logic        ovf_mem [DEPTH];

    state_t state_reg, state_next;
    logic [31:0]   smp_reg;
    logic [PW-1:0] pos_reg;
    logic [AW-1:0] ax_reg;
    logic          first_reg, last_reg;
    logic [63:0]   racc_reg;
    logic [AW-1:0] ridx_reg;
    logic          rovf_reg;
    logic [63:0]   sq_reg;
    logic [63:0]   nacc;
    logic [AW-1:0] nidx;
    logic          novf;
    logic [63:0]   nacc_reg;
    logic [AW-1:0] nidx_reg;
    logic          novf_reg;
    logic [6:0]    step_reg;
    logic [63:0]   rem_reg, quo_reg, num_reg;
    logic [65:0]   rrem_reg;
    logic          neg_reg;
    logic [63:0]   val_reg;
    logic [9:0]    opos_reg;
    logic          osat_reg, ovalid_reg;
    logic [AXW-1:0] alen;

    always_comb begin
        if (axis_len == 17'd0) alen = AXW'(1);
        else if ({15'd0, axis_len} > 32'(AXIS_MAX)) alen = AXW'(AXIS_MAX);
        else alen = AXW'(axis_len);
    end

    // accumulate
    logic signed [63:0] a_s, x_s, add_s, sum_s;
    logic [31:0] ax_abs;
    logic [64:0] usum;
    always_comb begin
        x_s    = 64'(signed'(smp_reg));
        ax_abs = smp_reg[31] ? 32'(-signed'(smp_reg)) : smp_reg;
        a_s    = first_reg ? 64'sd0 : signed'(racc_reg);
        add_s  = (mode == MODE_L1) ? signed'({32'd0, ax_abs}) : x_s;
        sum_s  = a_s + add_s;
        usum   = {1'b0, (first_reg ? 64'd0 : racc_reg)} + {1'b0, sq_reg};
        nacc = racc_reg; nidx = first_reg ? '0 : ridx_reg;
        novf = first_reg ? 1'b0 : rovf_reg;
        case (mode)
            MODE_SUM, MODE_MEAN, MODE_L1: begin
                if (a_s[63] == add_s[63] && sum_s[63] != a_s[63]) begin
                    nacc = a_s[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                    novf = 1'b1;
                end else begin
                    nacc = sum_s;
                end
            end
            MODE_L2: begin
                if (usum[64]) begin
                    nacc = '1; novf = 1'b1;
                end else begin
                    nacc = usum[63:0];
                end
            end
            MODE_MAX, MODE_ARGMAX: begin
                if (first_reg || x_s > signed'(racc_reg)) begin
                    nacc = x_s; nidx = ax_reg;
                end
            end
            default: begin
                if (first_reg || x_s < signed'(racc_reg)) begin
                    nacc = x_s; nidx = ax_reg;
                end
            end
        endcase
    end

    assign q_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (q_valid) state_next = ST_ACC;
            ST_ACC:    state_next = ST_WRITE;
            ST_WRITE: begin
                if (!last_reg) state_next = ST_IDLE;
                else if (mode == MODE_MEAN || mode == MODE_L2) state_next = ST_FINISH;
                else state_next = ST_OUT;
            end
            ST_FINISH: if (step_reg == 7'd0) state_next = ST_OUT;
            ST_OUT:    if (!ovalid_reg || m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    logic [64:0] dtrial;
    logic [63:0] dshift;
    logic [65:0] rtrial, rnext;
    always_comb begin
        dshift = {rem_reg[62:0], num_reg[63]};
        dtrial = {1'b0, dshift} - {1'b0, 64'(alen)};
        rnext  = {rrem_reg[63:0], num_reg[63:62]};
        rtrial = rnext - {quo_reg, 2'b01};
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                {last_reg, first_reg, ax_reg, pos_reg, smp_reg} <= q_data;
            end
            ST_ACC: begin
                racc_reg <= acc_mem[pos_reg];
                ridx_reg <= idx_mem[pos_reg];
                rovf_reg <= ovf_mem[pos_reg];
                sq_reg   <= 64'(ax_abs) * 64'(ax_abs);
            end
            ST_WRITE: begin
                acc_mem[pos_reg] <= nacc;
                idx_mem[pos_reg] <= nidx;
                ovf_mem[pos_reg] <= novf;
                nacc_reg <= nacc; nidx_reg <= nidx; novf_reg <= novf;
                rem_reg  <= '0; rrem_reg <= '0; quo_reg <= '0;
                neg_reg  <= nacc[63];
                num_reg  <= (mode == MODE_MEAN && nacc[63]) ? -nacc : nacc;
                step_reg <= (mode == MODE_MEAN) ? 7'd64 : 7'd32;
            end
            ST_FINISH: begin
                if (step_reg != 7'd0) begin
                    step_reg <= step_reg - 7'd1;
                    if (mode == MODE_MEAN) begin
                        num_reg <= {num_reg[62:0], 1'b0};
                        if (!dtrial[64]) begin
                            rem_reg <= dtrial[63:0]; quo_reg <= {quo_reg[62:0], 1'b1};
                        end else begin
                            rem_reg <= dshift; quo_reg <= {quo_reg[62:0], 1'b0};
                        end
                    end else begin
                        num_reg <= {num_reg[61:0], 2'b00};
                        if (!rtrial[65]) begin
                            rrem_reg <= rtrial; quo_reg <= {quo_reg[62:0], 1'b1};
                        end else begin
                            rrem_reg <= rnext; quo_reg <= {quo_reg[62:0], 1'b0};
                        end
                    end
                end
            end
            default: ;
        endcase
        if (state_reg == ST_OUT && (!ovalid_reg || m_tready)) begin
            opos_reg <= 10'(pos_reg);
            osat_reg <= novf_reg;
            if (mode == MODE_MEAN) val_reg <= neg_reg ? -quo_reg : quo_reg;
            else if (mode == MODE_L2) val_reg <= quo_reg;
            else if (mode == MODE_ARGMAX || mode == MODE_ARGMIN) val_reg <= 64'(nidx_reg);
            else val_reg <= nacc_reg;
        end
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && (!ovalid_reg || m_tready)) ovalid_reg <= 1'b1;
            else if (m_tready) ovalid_reg <= 1'b0;
        end
    end

    assign m_tvalid       = ovalid_reg;
    assign value          = val_reg;
    assign inner_position = opos_reg;
    assign saturated      = osat_reg;
endmodule

### hdl/axis_reduction_engine.sv
`timescale 1ns / 1ps
// Axis reduction engine: reduces a stream of Q16.16 samples along one tensor
// axis with one accumulator per inner position. Each sample passes through
// the back end's read-modify-write of the state memory in the steps accept,
// read and write. A group's last sample then goes through the serial divide
// (mean) or the serial square root (l2), where the mode has one, and loads
// the output register. A result waiting in the output register stalls the back
// end, and the two-entry queue then fills. Writing the mode, axis or inner
// register restarts the counters.
// Depends on are_pkg, are_front, are_queue and are_back.
module axis_reduction_engine
    import are_pkg::*;
#(
    parameter int INNER_MAX = 1024,
    parameter int AXIS_MAX  = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // value, inner_position, saturated, pad
);
    localparam int PW = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1;
    localparam int AW = (AXIS_MAX > 1) ? $clog2(AXIS_MAX) : 1;
    localparam int QW = 32 + PW + AW + 2;

    mode_t       mode_reg;
    logic [16:0] axis_len_reg;
    logic [10:0] inner_len_reg;
    logic        restart;
    logic        qi_valid, qi_ready, qo_valid, qo_ready;
    logic [QW-1:0] qi_data, qo_data;
    logic [63:0] value;
    logic [9:0]  inner_position;
    logic        saturated;

    assign cfg_ready = 1'b1;
    assign restart = cfg_valid && (cfg_index == REG_MODE || cfg_index == REG_AXIS
                                   || cfg_index == REG_INNER);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_SUM; axis_len_reg <= 17'd1; inner_len_reg <= 11'd1;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MODE:  mode_reg <= mode_t'(cfg_data[2:0]);
                REG_AXIS:  axis_len_reg <= cfg_data[16:0];
                REG_INNER: inner_len_reg <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    are_front #(.INNER_MAX(INNER_MAX), .AXIS_MAX(AXIS_MAX), .PW(PW), .AW(AW)) u_front (
        .aclk, .aresetn, .restart,
        .axis_len(axis_len_reg), .inner_len(inner_len_reg),
        .s_tvalid, .s_tready, .sample(s_tdata),
        .q_valid(qi_valid), .q_ready(qi_ready), .q_data(qi_data)
    );

    are_queue #(.W(QW)) u_queue (
        .aclk, .aresetn,
        .in_valid(qi_valid), .in_ready(qi_ready), .in_data(qi_data),
        .out_valid(qo_valid), .out_ready(qo_ready), .out_data(qo_data)
    );

    are_back #(.INNER_MAX(INNER_MAX), .AXIS_MAX(AXIS_MAX), .PW(PW), .AW(AW)) u_back (
        .aclk, .aresetn, .mode(mode_reg), .axis_len(axis_len_reg),
        .q_valid(qo_valid), .q_ready(qo_ready), .q_data(qo_data),
        .m_tvalid, .m_tready, .value, .inner_position, .saturated
    );

    assign m_tdata = {5'd0, saturated, inner_position, value};
endmodule

### verif/tb_axis_reduction_engine.sv
`timescale 1ns / 1ps
// Testbench for axis_reduction_engine: reduction of streamed samples in every mode,
// with a scoreboard class that predicts each group's result. Depends on are_pkg.
module tb_axis_reduction_engine;
    import are_pkg::*;

    localparam int INNER_LIMIT = 1024;
    localparam int AXIS_LIMIT  = 65536;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 300;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [63:0] value;
        logic [9:0]  pos;
        logic        sat;
    } group_result_t;

    class reduce_scoreboard;
        logic [63:0] acc [INNER_LIMIT];
        logic [15:0] best [INNER_LIMIT];
        logic        mark [INNER_LIMIT];
        int          inner_cnt;
        int          axis_cnt;
        mode_t       mode;
        logic [16:0] axis_len;
        logic [10:0] inner_len;
        group_result_t due_q[$];
        int errors;
        int samples;
        int results;
        int saturations;

        function new();
            mode = MODE_SUM;
            axis_len = 17'd1;
            inner_len = 11'd1;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                REG_MODE:  mode = mode_t'(data[2:0]);
                REG_AXIS:  axis_len = data[16:0];
                REG_INNER: inner_len = data[10:0];
                default:   return;
            endcase
            inner_cnt = 0;
            axis_cnt = 0;
        endfunction

        function automatic longint sat_add(longint a, longint b, inout bit ov);
            longint s;
            s = a + b;
            if (a[63] == b[63] && s[63] != a[63]) begin
                ov = 1'b1;
                s = a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
            end
            return s;
        endfunction

        function automatic logic [63:0] square_root(logic [63:0] n);
            logic [63:0] res;
            logic [63:0] b;
            res = '0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= res + b) begin
                    n = n - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function void note_sample(logic [31:0] raw);
            longint x;
            logic [63:0] ax;
            logic [63:0] sq;
            int alen;
            int ilen;
            int p;
            bit first;
            bit ov;
            group_result_t r;
            x = longint'($signed(raw));
            ax = (x < 0) ? -x : x;
            alen = (axis_len == 0) ? 1 : (axis_len > AXIS_LIMIT) ? AXIS_LIMIT : axis_len;
            ilen = (inner_len == 0) ? 1 : (inner_len > INNER_LIMIT) ? INNER_LIMIT : inner_len;
            p = inner_cnt % INNER_LIMIT;
            first = (axis_cnt == 0);
            ov = 1'b0;
            samples++;
            if (first) begin
                acc[p] = '0;
                best[p] = '0;
                mark[p] = 1'b0;
            end
            case (mode)
                MODE_SUM, MODE_MEAN: acc[p] = sat_add(acc[p], x, ov);
                MODE_L1:             acc[p] = sat_add(acc[p], ax, ov);
                MODE_L2: begin
                    sq = ax * ax;
                    if (acc[p] > ~sq) begin
                        acc[p] = '1;
                        ov = 1'b1;
                    end else begin
                        acc[p] = acc[p] + sq;
                    end
                end
                MODE_MAX, MODE_ARGMAX: begin
                    if (first || x > $signed(acc[p])) begin
                        acc[p] = x;
                        best[p] = axis_cnt[15:0];
                    end
                end
                default: begin
                    if (first || x < $signed(acc[p])) begin
                        acc[p] = x;
                        best[p] = axis_cnt[15:0];
                    end
                end
            endcase
            if (ov) mark[p] = 1'b1;
            if (axis_cnt + 1 >= alen) begin
                case (mode)
                    MODE_MEAN:              r.value = $signed(acc[p]) / longint'(alen);
                    MODE_L2:                r.value = square_root(acc[p]);
                    MODE_ARGMAX, MODE_ARGMIN: r.value = {48'd0, best[p]};
                    default:                r.value = acc[p];
                endcase
                r.pos = p[9:0];
                r.sat = mark[p];
                due_q.push_back(r);
            end
            if (inner_cnt + 1 >= ilen) begin
                inner_cnt = 0;
                axis_cnt = (axis_cnt + 1 >= alen) ? 0 : axis_cnt + 1;
            end else begin
                inner_cnt++;
            end
        endfunction

        function void check_result(logic [79:0] beat);
            group_result_t r;
            if (due_q.size() == 0) begin
                $error("unexpected result beat %h", beat);
                errors++;
                return;
            end
            r = due_q.pop_front();
            results++;
            if (beat[74]) saturations++;
            if (beat[63:0] !== r.value) begin
                $error("value: expected %h, got %h", r.value, beat[63:0]);
                errors++;
            end
            if (beat[73:64] !== r.pos) begin
                $error("inner_position: expected %0d, got %0d", r.pos, beat[73:64]);
                errors++;
            end
            if (beat[74] !== r.sat) begin
                $error("saturated: expected %0b, got %0b", r.sat, beat[74]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;

    reduce_scoreboard sb;
    int     idle_pct;
    int     stall_pct;
    int     hold_left;
    longint cycles;
    int     phases;

    axis_reduction_engine dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                m_tready <= (int'($urandom_range(99)) >= stall_pct);
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    task automatic send_sample(logic [31:0] x);
        while (int'($urandom_range(99)) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_sample(x);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.due_q.size() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(mode_t m, logic [31:0] alen, logic [31:0] ilen);
        drain();
        write_reg(REG_MODE, {$urandom} & 32'hFFFF_FFF8 | m);
        write_reg(REG_AXIS, alen);
        write_reg(REG_INNER, ilen);
        phases++;
        case (phases % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 74; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 74; end
            default: begin idle_pct = 23; stall_pct = 23; end
        endcase
    endtask

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(5))
            0, 1: return $urandom;
            2:    return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            3:    return $urandom_range(3) << 16;
            default: return 32'($signed($urandom_range(262143)) - 131072);
        endcase
    endfunction

    initial begin
        logic [31:0] tri_set [3];
        int alen;
        int ilen;
        int n;
        sb = new();
        cycles = 0;
        phases = 0;
        hold_left = 0;
        idle_pct = 0;
        stall_pct = 0;
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: plain sum of one element per group
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h0000_0000);
        send_sample(32'hFFFF_FFFF);

        // every mode on one three-element group with a tie on the maximum
        tri_set[0] = 32'h0003_0000;
        tri_set[1] = 32'hFFFE_0001;
        tri_set[2] = 32'h0003_0000;
        for (int m = 0; m < 8; m++) begin
            configure(mode_t'(m), 3, 1);
            for (int i = 0; i < 3; i++) send_sample(tri_set[i]);
        end

        // square accumulator overflows after four full-scale samples
        configure(MODE_L2, 5, 1);
        repeat (5) send_sample(32'h8000_0000);

        // out-of-range lengths clamp; an unused index leaves the stream alone
        configure(MODE_MAX, 0, 0);
        send_sample(32'h0001_0000);
        drain();
        write_reg(REG_UNUSED, 32'h0000_0005);
        send_sample(32'h8000_0000);
        configure(MODE_SUM, 32'h0001_FFFF, 1);
        repeat (20) send_sample(pick_sample());
        configure(MODE_L1, 1, 32'hFFFF_F7FF);
        repeat (64) send_sample(pick_sample());

        // receiver holds off while the sender keeps offering beats
        configure(MODE_MEAN, 2, 4);
        hold_left = 3000;
        repeat (200) send_sample(pick_sample());

        // random phases with mostly small shapes
        while (sb.samples < 1000) begin
            alen = $urandom_range(3) == 0 ? $urandom_range(40, 1) : $urandom_range(6, 1);
            ilen = $urandom_range(3) == 0 ? $urandom_range(64, 1) : $urandom_range(8, 1);
            configure(mode_t'($urandom_range(7)), alen, ilen);
            n = alen * ilen * $urandom_range(4, 1) + ($urandom_range(3) == 0 ? $urandom_range(7) : 0);
            if (n > 400) n = alen * ilen;
            for (int i = 0; i < n; i++) begin
                if (i == n / 2 && phases % 5 == 0) drain();
                send_sample(pick_sample());
            end
        end

        drain();
        $display("Covered %0d samples over %0d shape and mode settings.", sb.samples, phases);
        $display("Checked %0d group results, %0d of them saturated.", sb.results, sb.saturations);
        if (sb.errors == 0 && sb.due_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### axis_reduction_engine.f
hdl/are_pkg.sv
hdl/are_front.sv
hdl/are_queue.sv
hdl/are_back.sv
hdl/axis_reduction_engine.sv
verif/tb_axis_reduction_engine.sv
